@@ hdl/pps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the pure pursuit steering block
// Path depth, operation and status codes, register indexes, the quarter-wave
// sine coefficients and the result bundle of the divider.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int PATH_DEPTH = 1024;
    localparam int PATH_AW    = $clog2(PATH_DEPTH);
    localparam int CNT_W      = PATH_AW + 1;

    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    localparam logic [2:0] ST_TRACK   = 3'd0;
    localparam logic [2:0] ST_NO_PATH = 3'd1;
    localparam logic [2:0] ST_AT_GOAL = 3'd2;
    localparam logic [2:0] ST_NO_CAR  = 3'd3;
    localparam logic [2:0] ST_CLOSE   = 3'd4;

    localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
    localparam logic [1:0] REG_GOAL_TOL  = 2'd1;
    localparam logic [1:0] REG_SPEED     = 2'd2;

    localparam logic [62:0] CARROT_MIN_SQ = 63'd5;

    typedef struct packed {
        logic        busy;
        logic        sat;
        logic [31:0] quo;
    } t_div_res;

    function automatic logic signed [31:0] sine_coef(input logic [2:0] idx);
        logic signed [31:0] c;
        case (idx)
            3'd0:    c = 32'sd1686629713;
            3'd1:    c = 32'sd693598668;
            3'd2:    c = 32'sd85569306;
            3'd3:    c = 32'sd5026995;
            3'd4:    c = 32'sd172272;
            3'd5:    c = 32'sd3864;
            default: c = 32'sd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ hdl/pps_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_div: bit-serial divider for the steering magnitude
// Gives floor(num / den) in 32 bits, one quotient bit per cycle, and flags
// a quotient that does not fit in 32 bits straight away.
// ----------------------------------------------------------------------------
module pps_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [79:0]       i_num,
    input  wire logic [62:0]       i_den,
    output pps_pkg::t_div_res      o_res
);
    import pps_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [63:0]          r_rem;
    logic [31:0]          r_quo;
    logic                 r_sat;
    logic [63:0]          shifted;
    logic                 fits;
    logic                 start_sat;

    always_comb begin
        shifted   = {r_rem[62:0], r_quo[31]};
        fits      = shifted >= {1'b0, i_den};
        start_sat = {15'd0, i_num[79:32]} >= i_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_rem <= {16'd0, i_num[79:32]};
            r_quo <= i_num[31:0];
            r_sat <= start_sat;
            r_cnt <= start_sat ? '0 : DIV_CNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_rem <= fits ? shifted - {1'b0, i_den} : shifted;
            r_quo <= {r_quo[30:0], fits};
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_res.busy = (r_cnt != '0);
    assign o_res.sat  = r_sat;
    assign o_res.quo  = r_quo;

endmodule
`default_nettype wire

@@ hdl/pure_pursuit_steering.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pure_pursuit_steering: pure pursuit path tracker
// Holds a waypoint path in one memory and answers pose queries with a
// linear and an angular velocity command.
// ----------------------------------------------------------------------------
// Clear and append items are each handled in the idle state. A pose query
// that reaches a carrot steps through the waypoints from the carrot index
// on, and a query that ends early does less work; its pace is set by the
// single waypoint memory read port, the shared 33 by 33 bit multiplier
// that serves distances, the sine polynomial and the rotation, and the
// 32-step serial divider. One item is processed at a time, while a finished
// result may wait in the output register. The waypoint memory needs no
// clearing after reset.
module pure_pursuit_steering (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,   // coord_x, coord_y, heading
    input  wire logic [1:0]  s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata    // forward_vel, turn_rate, status
);
    import pps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_TH_LA, S_TH_TOL, S_DIFF, S_SQX, S_SQY, S_CMP,
        S_TX2, S_THORN, S_TFIN, S_ROT1, S_ROT2, S_ROT3, S_ROT4,
        S_NORM, S_L2A, S_L2B, S_PA, S_PB, S_DSTART, S_DWAIT, S_FIN
    } t_state;

    t_state r_state;

    logic [30:0]        r_la;
    logic [30:0]        r_tol;
    logic signed [31:0] r_speed;

    logic [CNT_W-1:0]   r_count;
    logic [PATH_AW-1:0] r_carrot;
    logic [PATH_AW-1:0] r_idx;
    logic               r_goal_phase;

    logic [63:0]        mem [PATH_DEPTH];
    logic [63:0]        r_rd;
    logic [PATH_AW-1:0] rd_addr;
    logic               mem_we;

    logic signed [31:0] r_rx;
    logic signed [31:0] r_ry;
    logic [15:0]        r_head;

    logic [61:0]        r_la2;
    logic [61:0]        r_tol2;
    logic signed [32:0] r_dx;
    logic signed [32:0] r_dy;
    logic signed [65:0] r_acc;
    logic [63:0]        r_dist;

    logic               r_trig_sin;
    logic [2:0]         r_hi;
    logic [31:0]        r_x2;
    logic signed [31:0] r_t;
    logic signed [31:0] r_cos;
    logic signed [31:0] r_sin;
    logic signed [35:0] r_lx;
    logic signed [35:0] r_ly;
    logic [30:0]        r_nx;
    logic [30:0]        r_ny;
    logic [1:0]         r_k;
    logic [62:0]        r_l2;
    logic [79:0]        r_num;

    logic [2:0]         r_status;
    logic [31:0]        r_fwd;
    logic [31:0]        r_turn;
    logic               r_out_valid;
    logic [71:0]        r_out_data;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;

    logic               in_acc;
    t_op                in_op;
    logic [CNT_W-1:0]   cnt_last;
    logic [CNT_W-1:0]   idx_next;
    logic [32:0]        dx_mag;
    logic [32:0]        dy_mag;
    logic [64:0]        sq_sum;
    logic [63:0]        sq_dist;
    logic [15:0]        ang;
    logic [14:0]        ang_r;
    logic [30:0]        ang_x;
    logic signed [65:0] h_q;
    logic signed [31:0] trig_val;
    logic signed [66:0] rot_w;
    logic signed [66:0] rot_q;
    logic [35:0]        nm_x;
    logic [35:0]        nm_y;
    logic [1:0]         nm_k;
    logic [62:0]        l2_sum;
    logic               too_close;
    logic [47:0]        p_b;
    logic [31:0]        spd_mag;
    logic               neg;
    logic [31:0]        lim;
    logic [31:0]        mag;
    logic               div_start;
    t_div_res           div_res;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_op    = t_op'(s_axis_tuser);
    assign cnt_last = r_count - CNT_W'(1);
    assign idx_next = {1'b0, r_idx} + CNT_W'(1);
    assign mem_we   = in_acc && (in_op == OP_APPEND) && (r_count < CNT_W'(PATH_DEPTH));
    assign div_start = (r_state == S_DSTART);

    always_comb begin
        case (r_state)
            S_TH_TOL: rd_addr = cnt_last[PATH_AW-1:0];
            S_CMP:    rd_addr = r_goal_phase ? r_carrot : idx_next[PATH_AW-1:0];
            default:  rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[PATH_AW-1:0]] <= s_axis_tdata[63:0];
        end
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        dx_mag = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
        dy_mag = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
        ang    = r_trig_sin ? r_head : r_head + 16'd16384;
        ang_r  = ang[14] ? 15'd16384 - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
        ang_x  = {ang_r, 16'd0};
        p_b    = 48'({17'd0, r_ny}) << (5'd17 - 5'(r_k));
        spd_mag = r_speed[31] ? 32'(-r_speed) : 32'(r_speed);
    end

    always_comb begin
        case (r_state)
            S_TH_LA:  begin mul_a = {2'b0, r_la};      mul_b = {2'b0, r_la};      end
            S_TH_TOL: begin mul_a = {2'b0, r_tol};     mul_b = {2'b0, r_tol};     end
            S_SQX:    begin mul_a = dx_mag;            mul_b = dx_mag;            end
            S_SQY:    begin mul_a = dy_mag;            mul_b = dy_mag;            end
            S_TX2:    begin mul_a = {2'b0, ang_x};     mul_b = {2'b0, ang_x};     end
            S_THORN:  begin mul_a = {1'b0, r_x2};      mul_b = 33'(r_t);          end
            S_TFIN:   begin mul_a = {2'b0, ang_x};     mul_b = 33'(r_t);          end
            S_ROT1:   begin mul_a = r_dx;              mul_b = 33'(r_cos);        end
            S_ROT2:   begin mul_a = r_dy;              mul_b = 33'(r_sin);        end
            S_ROT3:   begin mul_a = r_dy;              mul_b = 33'(r_cos);        end
            S_ROT4:   begin mul_a = r_dx;              mul_b = 33'(r_sin);        end
            S_L2A:    begin mul_a = {2'b0, r_nx};      mul_b = {2'b0, r_nx};      end
            S_L2B:    begin mul_a = {2'b0, r_ny};      mul_b = {2'b0, r_ny};      end
            S_PA:     begin mul_a = {1'b0, spd_mag};   mul_b = {1'b0, p_b[31:0]}; end
            S_PB:     begin mul_a = {1'b0, spd_mag};   mul_b = {17'd0, p_b[47:32]}; end
            default:  begin mul_a = '0;                mul_b = '0;                end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        sq_sum  = {1'b0, r_acc[63:0]} + {1'b0, mul_p[63:0]};
        sq_dist = sq_sum[64] ? '1 : sq_sum[63:0];
        h_q     = mul_p >>> 30;
        if (h_q > 66'sd1073741824) begin
            trig_val = 32'sd1073741824;
        end else if (h_q < 66'sd0) begin
            trig_val = 32'sd0;
        end else begin
            trig_val = h_q[31:0];
        end
        if (ang[15]) begin
            trig_val = -trig_val;
        end
        if (r_state == S_ROT2) begin
            rot_w = 67'(r_acc) + 67'(mul_p);
        end else begin
            rot_w = 67'(r_acc) - 67'(mul_p);
        end
        rot_q = (rot_w + 67'sd536870912) >>> 30;
    end

    always_comb begin
        nm_x = r_lx[35] ? 36'(-r_lx) : 36'(r_lx);
        nm_y = r_ly[35] ? 36'(-r_ly) : 36'(r_ly);
        nm_k = 2'd0;
        for (int i = 0; i < 3; i++) begin
            if (nm_x[35:31] != 5'd0 || nm_y[35:31] != 5'd0) begin
                nm_x = nm_x >> 1;
                nm_y = nm_y >> 1;
                nm_k = nm_k + 2'd1;
            end
        end
        l2_sum    = {1'b0, r_acc[61:0]} + {1'b0, mul_p[61:0]};
        too_close = ((r_k == 2'd0) && (l2_sum < CARROT_MIN_SQ)) || (l2_sum == '0);
        neg = r_speed[31] ^ r_ly[35];
        lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        mag = (div_res.sat || div_res.quo > lim) ? lim : div_res.quo;
    end

    pps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_l2),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la    <= 31'd65536;
            r_tol   <= 31'd16384;
            r_speed <= 32'sd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LOOKAHEAD: r_la    <= i_cfg_data[30:0];
                REG_GOAL_TOL:  r_tol   <= i_cfg_data[30:0];
                REG_SPEED:     r_speed <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_carrot    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_rx   <= s_axis_tdata[31:0];
                        r_ry   <= s_axis_tdata[63:32];
                        r_head <= s_axis_tdata[79:64];
                        case (in_op)
                            OP_CLEAR: begin
                                r_count  <= '0;
                                r_carrot <= '0;
                            end
                            OP_APPEND: begin
                                if (mem_we) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            OP_QUERY: begin
                                r_fwd  <= '0;
                                r_turn <= '0;
                                if (r_count == '0) begin
                                    r_status <= ST_NO_PATH;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_state <= S_TH_LA;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_TH_LA: begin
                    r_la2   <= mul_p[61:0];
                    r_state <= S_TH_TOL;
                end
                S_TH_TOL: begin
                    r_tol2       <= mul_p[61:0];
                    r_goal_phase <= 1'b1;
                    r_state      <= S_DIFF;
                end
                S_DIFF: begin
                    r_dx    <= 33'(signed'(r_rd[31:0])) - 33'(r_rx);
                    r_dy    <= 33'(signed'(r_rd[63:32])) - 33'(r_ry);
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_acc   <= mul_p;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_dist  <= sq_dist;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_goal_phase) begin
                        if (r_dist < {2'b0, r_tol2}) begin
                            r_status <= ST_AT_GOAL;
                            r_state  <= S_FIN;
                        end else begin
                            r_goal_phase <= 1'b0;
                            r_idx        <= r_carrot;
                            if ({1'b0, r_carrot} < r_count) begin
                                r_state <= S_DIFF;
                            end else begin
                                r_status <= ST_NO_CAR;
                                r_state  <= S_FIN;
                            end
                        end
                    end else if (r_dist >= {2'b0, r_la2}) begin
                        r_carrot   <= r_idx;
                        r_trig_sin <= 1'b0;
                        r_state    <= S_TX2;
                    end else if (idx_next < r_count) begin
                        r_idx   <= idx_next[PATH_AW-1:0];
                        r_state <= S_DIFF;
                    end else begin
                        r_status <= ST_NO_CAR;
                        r_state  <= S_FIN;
                    end
                end
                S_TX2: begin
                    r_x2    <= 32'(mul_p >>> 30);
                    r_t     <= sine_coef(3'd5);
                    r_hi    <= 3'd4;
                    r_state <= S_THORN;
                end
                S_THORN: begin
                    r_t <= sine_coef(r_hi) - h_q[31:0];
                    if (r_hi == 3'd0) begin
                        r_state <= S_TFIN;
                    end else begin
                        r_hi <= r_hi - 3'd1;
                    end
                end
                S_TFIN: begin
                    if (r_trig_sin) begin
                        r_sin   <= trig_val;
                        r_state <= S_ROT1;
                    end else begin
                        r_cos      <= trig_val;
                        r_trig_sin <= 1'b1;
                        r_state    <= S_TX2;
                    end
                end
                S_ROT1: begin
                    r_acc   <= mul_p;
                    r_state <= S_ROT2;
                end
                S_ROT2: begin
                    r_lx    <= rot_q[35:0];
                    r_state <= S_ROT3;
                end
                S_ROT3: begin
                    r_acc   <= mul_p;
                    r_state <= S_ROT4;
                end
                S_ROT4: begin
                    r_ly    <= rot_q[35:0];
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    r_nx    <= nm_x[30:0];
                    r_ny    <= nm_y[30:0];
                    r_k     <= nm_k;
                    r_state <= S_L2A;
                end
                S_L2A: begin
                    r_acc   <= mul_p;
                    r_state <= S_L2B;
                end
                S_L2B: begin
                    r_l2 <= l2_sum;
                    if (too_close) begin
                        r_status <= ST_CLOSE;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_PA;
                    end
                end
                S_PA: begin
                    r_acc   <= mul_p;
                    r_state <= S_PB;
                end
                S_PB: begin
                    r_num   <= {16'd0, r_acc[63:0]} + {mul_p[47:0], 32'd0};
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (!div_res.busy) begin
                        r_turn   <= neg ? 32'd0 - mag : mag;
                        r_fwd    <= r_speed;
                        r_status <= ST_TRACK;
                        r_state  <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {5'd0, r_status, r_turn, r_fwd};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

@@ hdl/pps_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_checker: port-level checks of the pure pursuit steering block
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata
);
    import pps_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[66:64] != ST_TRACK) |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("non-tracking result carries non-zero velocities");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result item present after reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_QUERY && !m_axis_tvalid)
        |=> !m_axis_tvalid)
        else $error("result item produced by a path update");

endmodule

bind pure_pursuit_steering pps_checker u_pps_checker (.*);
`default_nettype wire
